FILE: sv/sdcf_pkg.sv
package sdcf_pkg;

  localparam int unsigned ValueW    = 32;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned CntW      = $clog2(MaxDigits + 1);
  localparam int unsigned IdxW      = $clog2(MaxDigits);

  // floor(x / 10) == (x * RecipTen) >> RecipShift for every 32-bit x.
  localparam logic [ValueW-1:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int unsigned       RecipShift = 35;
  localparam int unsigned       ProdW      = 2 * ValueW;

  localparam logic [CharW-1:0] AsciiZero  = 8'h30;
  localparam logic [CharW-1:0] AsciiMinus = 8'h2D;
  localparam logic [CharW-1:0] AsciiComma = 8'h2C;
  localparam logic [CharW-1:0] AsciiCr    = 8'h0D;

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv,
    StSign,
    StDigit,
    StSep
  } state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic div;
    logic emit_sign;
    logic emit_digit;
    logic emit_sep;
  } cmd_t;

  typedef struct packed {
    logic q_zero;
    logic negative;
    logic cnt_one;
    logic out_free;
  } status_t;

endpackage

FILE: sv/sdcf_ctrl.sv
module sdcf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sdcf_pkg::status_t status_i,
  output sdcf_pkg::cmd_t    cmd_o
);

  sdcf_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sdcf_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sdcf_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = sdcf_pkg::StMul;
        end
      end
      sdcf_pkg::StMul: begin
        state_d = sdcf_pkg::StDiv;
      end
      sdcf_pkg::StDiv: begin
        if (!status_i.q_zero) begin
          state_d = sdcf_pkg::StMul;
        end else if (status_i.negative) begin
          state_d = sdcf_pkg::StSign;
        end else begin
          state_d = sdcf_pkg::StDigit;
        end
      end
      sdcf_pkg::StSign: begin
        if (status_i.out_free) begin
          state_d = sdcf_pkg::StDigit;
        end
      end
      sdcf_pkg::StDigit: begin
        if (status_i.out_free && status_i.cnt_one) begin
          state_d = sdcf_pkg::StSep;
        end
      end
      sdcf_pkg::StSep: begin
        if (status_i.out_free) begin
          state_d = sdcf_pkg::StIdle;
        end
      end
      default: begin
        state_d = sdcf_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      sdcf_pkg::StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      sdcf_pkg::StMul:   cmd_o.mul        = 1'b1;
      sdcf_pkg::StDiv:   cmd_o.div        = 1'b1;
      sdcf_pkg::StSign:  cmd_o.emit_sign  = status_i.out_free;
      sdcf_pkg::StDigit: cmd_o.emit_digit = status_i.out_free;
      sdcf_pkg::StSep:   cmd_o.emit_sep   = status_i.out_free;
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // An accepted item keeps the input stalled until its separator is queued.
  a_stall_after_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_stall_o)
    else $error("input not stalled after an item was accepted");

  a_sep_ends_item : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_sep |=> state_q == sdcf_pkg::StIdle)
    else $error("separator byte did not return the controller to idle");

  a_emit_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_sign || cmd_o.emit_digit || cmd_o.emit_sep) |-> status_i.out_free)
    else $error("byte emitted while the output register was occupied");

endmodule

FILE: sv/sdcf_dpath.sv
module sdcf_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sdcf_pkg::ValueW-1:0]   value_i,
  input  logic                          ends_line_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [sdcf_pkg::CharW-1:0]    char_byte_o,
  output logic                          last_byte_o,
  input  sdcf_pkg::cmd_t                cmd_i,
  output sdcf_pkg::status_t             status_o
);

  logic [sdcf_pkg::ValueW-1:0] mag_q;
  logic                        neg_q;
  logic                        eol_q;
  logic [sdcf_pkg::ProdW-1:0]  prod_q;
  logic [sdcf_pkg::DigitW-1:0] digits_q [sdcf_pkg::MaxDigits];
  logic [sdcf_pkg::CntW-1:0]   cnt_q;
  logic                        out_valid_q;
  logic [sdcf_pkg::CharW-1:0]  char_q;
  logic                        last_q;

  logic [sdcf_pkg::ValueW-1:0] quot;
  logic [sdcf_pkg::ValueW-1:0] rem;
  logic [sdcf_pkg::ValueW-1:0] in_mag;
  logic [sdcf_pkg::CntW-1:0]   cnt_dec;
  logic [sdcf_pkg::IdxW-1:0]   wr_idx;
  logic [sdcf_pkg::IdxW-1:0]   rd_idx;
  logic                        emit;
  logic                        out_free;

  assign in_mag  = value_i[sdcf_pkg::ValueW-1] ? (~value_i + 32'd1) : value_i;
  assign quot    = {{sdcf_pkg::RecipShift - sdcf_pkg::ValueW{1'b0}},
                    prod_q[sdcf_pkg::ProdW-1:sdcf_pkg::RecipShift]};
  assign rem     = mag_q - (quot << 3) - (quot << 1);
  assign cnt_dec = cnt_q - 4'd1;
  assign wr_idx  = cnt_q[sdcf_pkg::IdxW-1:0];
  assign rd_idx  = cnt_dec[sdcf_pkg::IdxW-1:0];
  assign emit    = cmd_i.emit_sign | cmd_i.emit_digit | cmd_i.emit_sep;
  assign out_free = !out_valid_q || !out_stall_i;

  // Operand and digit registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= in_mag;
      neg_q <= value_i[sdcf_pkg::ValueW-1];
      eol_q <= ends_line_i;
    end else if (cmd_i.div) begin
      mag_q <= quot;
    end
    if (cmd_i.mul) begin
      prod_q <= {{sdcf_pkg::ValueW{1'b0}}, mag_q} * {{sdcf_pkg::ValueW{1'b0}}, sdcf_pkg::RecipTen};
    end
    if (cmd_i.div) begin
      digits_q[wr_idx] <= rem[sdcf_pkg::DigitW-1:0];
    end
    if (cmd_i.emit_sign) begin
      char_q <= sdcf_pkg::AsciiMinus;
      last_q <= 1'b0;
    end else if (cmd_i.emit_digit) begin
      char_q <= sdcf_pkg::AsciiZero | {4'b0, digits_q[rd_idx]};
      last_q <= 1'b0;
    end else if (cmd_i.emit_sep) begin
      char_q <= eol_q ? sdcf_pkg::AsciiCr : sdcf_pkg::AsciiComma;
      last_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div) begin
        cnt_q <= cnt_q + 4'd1;
      end else if (cmd_i.emit_digit) begin
        cnt_q <= cnt_dec;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.q_zero   = (quot == '0);
  assign status_o.negative = neg_q;
  assign status_o.cnt_one  = (cnt_q == 4'd1);
  assign status_o.out_free = out_free;

  assign out_valid_o = out_valid_q;
  assign char_byte_o = char_q;
  assign last_byte_o = last_q;

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'(sdcf_pkg::MaxDigits))
    else $error("digit count beyond ten");

  a_digit_stored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_digit |-> cnt_q != '0)
    else $error("digit emitted with no digit stored");

  a_last_is_sep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |->
      (char_q == sdcf_pkg::AsciiComma || char_q == sdcf_pkg::AsciiCr))
    else $error("last byte is not a separator");

endmodule

FILE: sv/signed_decimal_csv_formatter.sv
// Prints one signed 32-bit value per input item as decimal ASCII text for a
// comma separated line, one byte per output item: a minus sign for negative
// values, the digits most significant first without leading zeros (zero
// prints as a single '0'), then a comma, or a carriage return when
// ends_line_i is set. The closing byte carries last_byte_o. The most
// negative value prints correctly. An item with d digits is accepted, then
// converted by d divide-by-ten steps (each a registered 32x32 reciprocal
// multiply followed by a remainder step), then emitted at one byte per
// cycle while the output is not stalled. The input is stalled while an
// item is being converted and emitted; the result register lets the next
// item be accepted while the last byte of the previous one still waits to
// be taken.
module signed_decimal_csv_formatter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [sdcf_pkg::ValueW-1:0] value_i,
  input  logic                        ends_line_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [sdcf_pkg::CharW-1:0]  char_byte_o,
  output logic                        last_byte_o
);

  // Commands from the controller and status back from the datapath.
  sdcf_pkg::cmd_t    cmd;
  sdcf_pkg::status_t status;

  // The controller sequences load, the divide-by-ten loop and byte output.
  sdcf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the magnitude, the digit store and the output register.
  sdcf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .ends_line_i (ends_line_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .char_byte_o (char_byte_o),
    .last_byte_o (last_byte_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule
